/* rtl/core/abt_pkg.sv */
// Package for the address ban table: transaction types, action and status codes,
// table sizing and id limit. Used by every module of the block; no dependencies.
`default_nettype none

package abt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int SLOT_BITS     = $clog2(TABLE_ENTRIES);
  localparam int ID_BITS       = 16;
  localparam int ID_FIELD_BITS = 16;

  // Largest id: lesser of the counter range and the id field range.
  localparam logic [31:0] ID_LIMIT = (ID_BITS >= ID_FIELD_BITS) ?
    32'((64'(1) << ID_FIELD_BITS) - 64'(1)) : 32'((64'(1) << ID_BITS) - 64'(1));

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_ADDR  = 3'd1;
  localparam logic [2:0] ST_ALREADY   = 3'd2;
  localparam logic [2:0] ST_DUP_ID    = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;
  localparam logic [2:0] ST_IDS_OUT   = 3'd6;

  typedef struct packed {
    logic [1:0]               action;
    logic [63:0]              addr_high;
    logic [63:0]              addr_low;
    logic                     addr_is_v4;
    logic                     addr_present;
    logic [ID_FIELD_BITS-1:0] requested_id;
  } in_item_t;

  typedef struct packed {
    logic [ID_FIELD_BITS-1:0] result_id;
    logic                     hit;
    logic [2:0]               status;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic [1:0]               action;
    logic [63:0]              addr_high;
    logic [63:0]              addr_low;
    logic                     present;
    logic                     loopback;
    logic [ID_FIELD_BITS-1:0] req_id;
  } cmd_t;

  typedef enum logic [1:0] {
    S_LOOK   = 2'b01,
    S_COMMIT = 2'b10
  } back_state_t;

endpackage

`default_nettype wire

/* rtl/core/abt_front.sv */
// Front of the address ban table: accepts input transactions, maps IPv4 to
// ::ffff form, flags loopback, and queues commands (two deep). Uses abt_pkg.
`default_nettype none

module abt_front (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_push,
  output logic             in_full,
  input  abt_pkg::in_item_t in_item,
  output logic             q_valid,
  output abt_pkg::cmd_t    q_cmd,
  input  wire              q_take
);

  abt_pkg::cmd_t fq_mem_r [2];
  logic       fq_wptr_r, fq_wptr_nxt;
  logic       fq_rptr_r, fq_rptr_nxt;
  logic [1:0] fq_cnt_r, fq_cnt_nxt;

  logic          push_fire;
  logic          pop_fire;
  abt_pkg::cmd_t cmd_in;
  logic [63:0]   canon_hi;
  logic [63:0]   canon_lo;

  always_comb begin
    if (in_item.addr_is_v4) begin
      canon_hi = 64'd0;
      canon_lo = {32'h0000_ffff, in_item.addr_low[31:0]};
    end else begin
      canon_hi = in_item.addr_high;
      canon_lo = in_item.addr_low;
    end
    cmd_in.action    = in_item.action;
    cmd_in.addr_high = canon_hi;
    cmd_in.addr_low  = canon_lo;
    cmd_in.present   = in_item.addr_present;
    // loopback: ::1 or ::ffff:127.x.y.z
    cmd_in.loopback  = (canon_hi == 64'd0) &&
                       ((canon_lo == 64'd1) ||
                        ((canon_lo[63:32] == 32'h0000_ffff) && (canon_lo[31:24] == 8'd127)));
    cmd_in.req_id    = in_item.requested_id;
  end

  assign in_full   = (fq_cnt_r == 2'd2);
  assign push_fire = in_push && !in_full;
  assign q_valid   = (fq_cnt_r != 2'd0);
  assign pop_fire  = q_take && q_valid;
  assign q_cmd     = fq_mem_r[fq_rptr_r];

  always_comb begin
    fq_wptr_nxt = push_fire ? ~fq_wptr_r : fq_wptr_r;
    fq_rptr_nxt = pop_fire  ? ~fq_rptr_r : fq_rptr_r;
    fq_cnt_nxt  = fq_cnt_r + 2'(push_fire) - 2'(pop_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fq_wptr_r <= 1'b0;
      fq_rptr_r <= 1'b0;
      fq_cnt_r  <= 2'd0;
    end else begin
      fq_wptr_r <= fq_wptr_nxt;
      fq_rptr_r <= fq_rptr_nxt;
      fq_cnt_r  <= fq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      fq_mem_r[fq_wptr_r] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/abt_back.sv */
// Back of the address ban table: holds the entries, compares all of them in
// parallel, then commits the decision, and queues results. Uses abt_pkg.
`default_nettype none

module abt_back (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                q_valid,
  input  abt_pkg::cmd_t      q_cmd,
  output logic               q_take,
  output logic               out_empty,
  input  wire                out_pop,
  output abt_pkg::out_item_t out_item
);

  localparam int N = abt_pkg::TABLE_ENTRIES;

  // Table: each entry compared at its own place.
  logic [N-1:0]                      valid_r;
  logic [63:0]                       hi_r  [N];
  logic [63:0]                       lo_r  [N];
  logic [abt_pkg::ID_FIELD_BITS-1:0] id_r  [N];

  logic [abt_pkg::ID_BITS-1:0] ctr_r, ctr_nxt;
  abt_pkg::back_state_t        state_r, state_nxt;
  abt_pkg::cmd_t               cmd_r;
  logic [N-1:0]                addr_match_r;
  logic [N-1:0]                id_match_r;

  abt_pkg::out_item_t oq_mem_r [2];
  logic               oq_wptr_r, oq_rptr_r;
  logic [1:0]         oq_cnt_r, oq_cnt_nxt;
  logic               oq_full;
  logic               oq_push;
  logic               oq_pop;

  logic                          any_addr, any_id, any_free, req_nz;
  logic [abt_pkg::SLOT_BITS-1:0] free_idx, id_idx;
  logic [31:0]                   req32, ctr32;
  logic                          add_ok, rem_ok;
  abt_pkg::out_item_t            res;

  assign q_take = (state_r == abt_pkg::S_LOOK) && q_valid;

  always_comb begin
    free_idx = '0;
    id_idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_idx = abt_pkg::SLOT_BITS'(i);
      if (id_match_r[i]) id_idx = abt_pkg::SLOT_BITS'(i);
    end
  end

  assign any_addr = |addr_match_r;
  assign any_id   = |id_match_r;
  assign any_free = ~&valid_r;
  assign req_nz   = (cmd_r.req_id != '0);
  assign req32    = 32'(cmd_r.req_id);
  assign ctr32    = 32'(ctr_r);

  // Decide the outcome of the held command; refusal order matters on add.
  always_comb begin
    res     = '0;
    add_ok  = 1'b0;
    rem_ok  = 1'b0;
    ctr_nxt = ctr_r;
    unique case (cmd_r.action)
      abt_pkg::ACT_ADD: begin
        priority if (!cmd_r.present || cmd_r.loopback) begin
          res.status = abt_pkg::ST_BAD_ADDR;
        end else if (any_addr) begin
          res.status = abt_pkg::ST_ALREADY;
        end else if (req_nz && any_id) begin
          res.status = abt_pkg::ST_DUP_ID;
        end else if (req_nz ? (req32 > abt_pkg::ID_LIMIT) : (ctr32 >= abt_pkg::ID_LIMIT)) begin
          res.status = abt_pkg::ST_IDS_OUT;
        end else if (!any_free) begin
          res.status = abt_pkg::ST_FULL;
        end else begin
          add_ok  = 1'b1;
          res.hit = 1'b1;
          if (req_nz) begin
            res.result_id = cmd_r.req_id;
            if (req32 > ctr32) ctr_nxt = abt_pkg::ID_BITS'(req32);
          end else begin
            ctr_nxt       = ctr_r + abt_pkg::ID_BITS'(1);
            res.result_id = abt_pkg::ID_FIELD_BITS'(ctr32 + 32'd1);
          end
        end
      end
      abt_pkg::ACT_REMOVE: begin
        if (req_nz && any_id) begin
          rem_ok  = 1'b1;
          res.hit = 1'b1;
        end else begin
          res.status = abt_pkg::ST_NOT_FOUND;
        end
      end
      abt_pkg::ACT_QUERY: begin
        if (!cmd_r.present) begin
          res.status = abt_pkg::ST_BAD_ADDR;
        end else begin
          res.hit = any_addr;
        end
      end
      default: res = '0;
    endcase
  end

  assign oq_full = (oq_cnt_r == 2'd2);
  assign oq_push = (state_r == abt_pkg::S_COMMIT) && !oq_full;
  assign out_empty = (oq_cnt_r == 2'd0);
  assign oq_pop  = out_pop && !out_empty;
  assign out_item = oq_mem_r[oq_rptr_r];
  assign oq_cnt_nxt = oq_cnt_r + 2'(oq_push) - 2'(oq_pop);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      abt_pkg::S_LOOK:   if (q_valid) state_nxt = abt_pkg::S_COMMIT;
      abt_pkg::S_COMMIT: if (!oq_full) state_nxt = abt_pkg::S_LOOK;
      default:           state_nxt = abt_pkg::S_LOOK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= abt_pkg::S_LOOK;
      ctr_r     <= '0;
      valid_r   <= '0;
      oq_wptr_r <= 1'b0;
      oq_rptr_r <= 1'b0;
      oq_cnt_r  <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      oq_cnt_r <= oq_cnt_nxt;
      if (oq_push) begin
        oq_wptr_r <= ~oq_wptr_r;
        ctr_r     <= ctr_nxt;
        if (add_ok) valid_r[free_idx] <= 1'b1;
        if (rem_ok) valid_r[id_idx]   <= 1'b0;
      end
      if (oq_pop) oq_rptr_r <= ~oq_rptr_r;
    end
  end

  // Payload registers: table contents, held command, match vectors, results.
  always_ff @(posedge clk) begin
    if (q_take) begin
      cmd_r <= q_cmd;
      for (int i = 0; i < N; i++) begin
        addr_match_r[i] <= valid_r[i] && (hi_r[i] == q_cmd.addr_high) &&
                           (lo_r[i] == q_cmd.addr_low);
        id_match_r[i]   <= valid_r[i] && (id_r[i] == q_cmd.req_id);
      end
    end
    if (oq_push && add_ok) begin
      hi_r[free_idx] <= cmd_r.addr_high;
      lo_r[free_idx] <= cmd_r.addr_low;
      id_r[free_idx] <= res.result_id;
    end
    if (oq_push) oq_mem_r[oq_wptr_r] <= res;
  end

  a_take_then_commit: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |=> state_r == abt_pkg::S_COMMIT)
    else $error("command taken but back did not move to commit");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (oq_push && add_ok) |=> $countones(valid_r) == $past($countones(valid_r)) + 1)
    else $error("successful add did not occupy exactly one entry");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (oq_push && rem_ok) |=> $countones(valid_r) + 1 == $past($countones(valid_r)))
    else $error("successful remove did not free exactly one entry");

  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= 2'd2)
    else $error("result queue overflow");

endmodule

`default_nettype wire

/* rtl/core/address_ban_table.sv */
// Address ban table top level: front classifier plus back table engine.
// Depends on abt_pkg, abt_front and abt_back.
//
// Usage:
//   Input channel: drive in_item and raise in_push; a transaction is taken
//   at a rising edge where in_push is high and in_full is low. The front
//   buffers up to two commands.
//   Result channel: while out_empty is low, out_item holds the oldest
//   result; raise out_pop to take it. Exactly one result per input, in order.
//   Path: an accepted input waits in the front queue; the back takes it in
//   its look state, registering the match vectors, and in its commit state
//   writes the result queue. Pacing: the back takes no new command until
//   the previous one commits, set by the compare-then-commit loop over the
//   table registers: every entry is compared at once and the add/remove
//   decision is written in commit before the following command compares.
//   Stall: if the two-deep result queue is full, the back holds its command
//   in commit; the front keeps accepting until its own queue fills.
//   Reset (rst_n low, synchronous): all entries become invalid, the id
//   counter clears, and both queues empty. No clearing pass is needed.
`default_nettype none

module address_ban_table (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_push,
  output logic               in_full,
  input  abt_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  wire                out_pop,
  output abt_pkg::out_item_t out_item
);

  logic          q_valid;
  logic          q_take;
  abt_pkg::cmd_t q_cmd;

  abt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_take  (q_take)
  );

  abt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_take    (q_take),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
